// File: sv/cpm_pkg.sv
// ============================================================================
// Color palette memory unit package
// Shared types, widths and codes for the palette memory unit.
// ============================================================================
package cpm_pkg;

    localparam int DEFAULT_PALETTE_COUNT = 8;

    localparam int OPCODE_W     = 3;
    localparam int PAL_NUM_W    = 3;
    localparam int COLOR_NUM_W  = 2;
    localparam int ENTRY_ADDR_W = PAL_NUM_W + COLOR_NUM_W;
    localparam int INDEX_W      = ENTRY_ADDR_W + 1;
    localparam int CHAN_W       = 5;
    localparam int ENTRY_W      = 3 * CHAN_W;
    localparam int BYTE_W       = 8;
    localparam int RGBA_W       = 32;

    localparam logic [BYTE_W-1:0] MISSING_PALETTE_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE         = 8'hFF;
    localparam logic [RGBA_W-1:0] OPAQUE_BLACK         = 32'hFF00_0000;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WR_INDEX = 3'd0,
        OP_RD_INDEX = 3'd1,
        OP_WR_DATA  = 3'd2,
        OP_RD_DATA  = 3'd3,
        OP_LOOKUP   = 3'd4
    } opcode_t;

    // One request beat as held in the input register.
    typedef struct packed {
        logic [OPCODE_W-1:0]    opcode;
        logic                   which_table;
        logic [BYTE_W-1:0]      data_byte;
        logic [PAL_NUM_W-1:0]   palette_number;
        logic [COLOR_NUM_W-1:0] color_number;
    } req_item_t;

    // Control toward one palette bank.
    typedef struct packed {
        logic                   wr_index;
        logic                   wr_data;
        logic                   lookup;
        logic [BYTE_W-1:0]      data;
        logic [PAL_NUM_W-1:0]   palette;
        logic [COLOR_NUM_W-1:0] color;
    } bank_cmd_t;

    // What one palette bank shows back.
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               autoinc;
        logic               present;
        logic [ENTRY_W-1:0] entry;
    } bank_view_t;

endpackage

// File: sv/cpm_if.sv
// ============================================================================
// Color palette memory unit channels
// Valid/ready channels for request beats and result beats.
// ============================================================================
interface cpm_req_if;
    import cpm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OPCODE_W-1:0]    opcode;
    logic                   which_table;
    logic [BYTE_W-1:0]      data_byte;
    logic [PAL_NUM_W-1:0]   palette_number;
    logic [COLOR_NUM_W-1:0] color_number;

    modport source (
        output valid, opcode, which_table, data_byte, palette_number, color_number,
        input  ready
    );
    modport sink (
        input  valid, opcode, which_table, data_byte, palette_number, color_number,
        output ready
    );
endinterface

interface cpm_rsp_if;
    import cpm_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_byte;
    logic [RGBA_W-1:0] rgba_color;

    modport source (
        output valid, read_byte, rgba_color,
        input  ready
    );
    modport sink (
        input  valid, read_byte, rgba_color,
        output ready
    );
endinterface

// File: sv/cpm_palette_bank.sv
// ============================================================================
// Palette bank
// One palette memory with its index register and auto-increment bit.
// ============================================================================
module cpm_palette_bank #(
    parameter int PALETTE_COUNT = cpm_pkg::DEFAULT_PALETTE_COUNT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cpm_pkg::bank_cmd_t cmd,
    output cpm_pkg::bank_view_t view
);
    import cpm_pkg::*;

    localparam int ENTRY_COUNT = PALETTE_COUNT * 4;
    localparam int AW          = $clog2(ENTRY_COUNT);
    localparam logic [PAL_NUM_W:0] PAL_LIMIT = (PAL_NUM_W + 1)'(PALETTE_COUNT);

    logic [ENTRY_W-1:0]      store_reg [ENTRY_COUNT];
    logic [INDEX_W-1:0]      index_reg;
    logic [INDEX_W-1:0]      index_next;
    logic                    autoinc_reg;
    logic                    autoinc_next;
    logic [ENTRY_ADDR_W-1:0] addr;
    logic                    present;
    logic [ENTRY_W-1:0]      cur;
    logic [ENTRY_W-1:0]      entry_next;
    logic [CHAN_W-1:0]       r_new;
    logic [CHAN_W-1:0]       g_new;
    logic [CHAN_W-1:0]       b_new;

    // Lookups address by palette and color; port accesses by the byte index.
    assign addr    = cmd.lookup ? {cmd.palette, cmd.color}
                                : index_reg[INDEX_W-1:1];
    assign present = {1'b0, addr[ENTRY_ADDR_W-1:COLOR_NUM_W]} < PAL_LIMIT;
    assign cur     = present ? store_reg[addr[AW-1:0]] : '0;

    always_comb
    begin
        r_new = cur[CHAN_W-1:0];
        g_new = cur[2*CHAN_W-1:CHAN_W];
        b_new = cur[3*CHAN_W-1:2*CHAN_W];
        if (!index_reg[0])
        begin
            r_new      = cmd.data[4:0];
            g_new[2:0] = cmd.data[7:5];
        end
        else
        begin
            g_new[4:3] = cmd.data[1:0];
            b_new      = cmd.data[6:2];
        end
        entry_next = {b_new, g_new, r_new};
    end

    always_comb
    begin
        index_next   = index_reg;
        autoinc_next = autoinc_reg;
        if (cmd.wr_index)
        begin
            index_next   = cmd.data[INDEX_W-1:0];
            autoinc_next = cmd.data[BYTE_W-1];
        end
        else if (cmd.wr_data && autoinc_reg)
        begin
            index_next = index_reg + INDEX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg   <= '0;
            autoinc_reg <= 1'b0;
        end
        else
        begin
            index_reg   <= index_next;
            autoinc_reg <= autoinc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRY_COUNT; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (cmd.wr_data && present)
        begin
            store_reg[addr[AW-1:0]] <= entry_next;
        end
    end

    assign view.index   = index_reg;
    assign view.autoinc = autoinc_reg;
    assign view.present = present;
    assign view.entry   = cur;

endmodule

// File: sv/cpm_color_correct.sv
// ============================================================================
// Color correction
// Mixes the 5-bit channels and expands them to an opaque 8-bit RGBA word.
// ============================================================================
module cpm_color_correct (
    input  logic [cpm_pkg::ENTRY_W-1:0] entry,
    output logic [cpm_pkg::RGBA_W-1:0]  rgba
);
    import cpm_pkg::*;

    localparam int SUM_W = CHAN_W + 5;

    logic [SUM_W-1:0]  r5;
    logic [SUM_W-1:0]  g5;
    logic [SUM_W-1:0]  b5;
    logic [SUM_W-1:0]  sum_r;
    logic [SUM_W-1:0]  sum_g;
    logic [SUM_W-1:0]  sum_b;
    logic [CHAN_W-1:0] cr;
    logic [CHAN_W-1:0] cg;
    logic [CHAN_W-1:0] cb;

    assign r5 = SUM_W'(entry[CHAN_W-1:0]);
    assign g5 = SUM_W'(entry[2*CHAN_W-1:CHAN_W]);
    assign b5 = SUM_W'(entry[3*CHAN_W-1:2*CHAN_W]);

    // Weights sum to 32, so each sum fits ten bits and the top five bits
    // are the corrected channel.
    assign sum_r = r5 * SUM_W'(26) + g5 * SUM_W'(4)  + b5 * SUM_W'(2);
    assign sum_g = r5 * SUM_W'(6)  + g5 * SUM_W'(24) + b5 * SUM_W'(2);
    assign sum_b = r5 * SUM_W'(2)  + g5 * SUM_W'(4)  + b5 * SUM_W'(26);

    assign cr = sum_r[SUM_W-1:5];
    assign cg = sum_g[SUM_W-1:5];
    assign cb = sum_b[SUM_W-1:5];

    assign rgba = {ALPHA_OPAQUE,
                   cb, cb[4:2],
                   cg, cg[4:2],
                   cr, cr[4:2]};

endmodule

// File: sv/color_palette_memory_unit.sv
// ============================================================================
// Color palette memory unit: a beat passes an input and an output register.
// Throughput is one request beat per cycle unless results stall, set by the
// single compute stage. Reset clears both palette memories, index registers
// and auto-increment bits at once; the unit accepts beats right after reset.
// ============================================================================
module color_palette_memory_unit #(
    parameter int PALETTE_COUNT = cpm_pkg::DEFAULT_PALETTE_COUNT
) (
    input logic    clk,
    input logic    rst_n,
    cpm_req_if.sink   req,
    cpm_rsp_if.source rsp
);
    import cpm_pkg::*;

    // The unit holds a background and an object palette bank. Each request
    // beat lands in an input register; from there the selected bank is read,
    // updated as it moves on, and any result goes to the output register.
    // Index writes and data writes produce no result beat. Index reads, data
    // reads and color lookups produce exactly one.

    req_item_t         req_reg;
    logic              s1_valid_reg;
    logic              s1_fire;
    logic              out_free;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] read_byte_reg;
    logic [RGBA_W-1:0] rgba_reg;

    opcode_t           op;
    bank_cmd_t         bg_cmd;
    bank_cmd_t         obj_cmd;
    bank_view_t        bg_view;
    bank_view_t        obj_view;
    bank_view_t        view;
    logic [RGBA_W-1:0] corrected;
    logic              has_result;
    logic [BYTE_W-1:0] byte_res;
    logic [RGBA_W-1:0] rgba_res;

    // ------------------------------------------------------------------
    // Flow control. The compute stage moves when the output register is
    // empty or being drained this cycle, and the input register refills
    // whenever it is empty or moving on.
    // ------------------------------------------------------------------
    assign out_free  = !out_valid_reg || rsp.ready;
    assign s1_fire   = s1_valid_reg && out_free;
    assign req.ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_reg.opcode         <= req.opcode;
            req_reg.which_table    <= req.which_table;
            req_reg.data_byte      <= req.data_byte;
            req_reg.palette_number <= req.palette_number;
            req_reg.color_number   <= req.color_number;
        end
    end

    // ------------------------------------------------------------------
    // Bank control. Writes only take effect when the held beat moves on,
    // so a stalled beat never touches the state twice.
    // ------------------------------------------------------------------
    assign op = opcode_t'(req_reg.opcode);

    always_comb
    begin
        bg_cmd.wr_index  = s1_fire && (op == OP_WR_INDEX) && !req_reg.which_table;
        bg_cmd.wr_data   = s1_fire && (op == OP_WR_DATA)  && !req_reg.which_table;
        bg_cmd.lookup    = (op == OP_LOOKUP);
        bg_cmd.data      = req_reg.data_byte;
        bg_cmd.palette   = req_reg.palette_number;
        bg_cmd.color     = req_reg.color_number;

        obj_cmd          = bg_cmd;
        obj_cmd.wr_index = s1_fire && (op == OP_WR_INDEX) && req_reg.which_table;
        obj_cmd.wr_data  = s1_fire && (op == OP_WR_DATA)  && req_reg.which_table;
    end

    cpm_palette_bank #(
        .PALETTE_COUNT(PALETTE_COUNT)
    ) u_bg_bank (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (bg_cmd),
        .view (bg_view)
    );

    cpm_palette_bank #(
        .PALETTE_COUNT(PALETTE_COUNT)
    ) u_obj_bank (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (obj_cmd),
        .view (obj_view)
    );

    assign view = req_reg.which_table ? obj_view : bg_view;

    cpm_color_correct u_color_correct (
        .entry(view.entry),
        .rgba (corrected)
    );

    // ------------------------------------------------------------------
    // Result forming. The index reads back with bit 6 always set. A data
    // read from a palette beyond the configured count returns all ones,
    // and a lookup there returns opaque black.
    // ------------------------------------------------------------------
    always_comb
    begin
        has_result = 1'b0;
        byte_res   = '0;
        rgba_res   = '0;
        unique case (op)
            OP_RD_INDEX:
            begin
                has_result = 1'b1;
                byte_res   = {view.autoinc, 1'b1, view.index};
            end
            OP_RD_DATA:
            begin
                has_result = 1'b1;
                if (!view.present)
                begin
                    byte_res = MISSING_PALETTE_BYTE;
                end
                else if (!view.index[0])
                begin
                    byte_res = {view.entry[7:5], view.entry[4:0]};
                end
                else
                begin
                    byte_res = {1'b0, view.entry[14:10], view.entry[9:8]};
                end
            end
            OP_LOOKUP:
            begin
                has_result = 1'b1;
                rgba_res   = view.present ? corrected : OPAQUE_BLACK;
            end
            OP_WR_INDEX, OP_WR_DATA:
            begin
                has_result = 1'b0;
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register. It parts the result channel from the compute stage,
    // so a new request beat is taken while a result beat waits.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= has_result;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            read_byte_reg <= byte_res;
            rgba_reg      <= rgba_res;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_byte  = read_byte_reg;
    assign rsp.rgba_color = rgba_reg;

`ifndef ASSERT_OFF
    // The input side only stalls behind a held beat whose result is blocked.
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (s1_valid_reg && out_valid_reg && !rsp.ready))
        else $error("request side stalled without a blocked result");

    // A reading beat that moves on always leaves a result beat behind.
    a_result_made: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && has_result) |=> rsp.valid)
        else $error("result beat lost after a reading beat");

    // A background index write lands in the index register.
    a_bg_index_wr: assert property (@(posedge clk) disable iff (!rst_n)
        bg_cmd.wr_index |=> (bg_view.index == $past(req_reg.data_byte[INDEX_W-1:0])))
        else $error("background index write not taken");

    // An object index write lands in the index register.
    a_obj_index_wr: assert property (@(posedge clk) disable iff (!rst_n)
        obj_cmd.wr_index |=> (obj_view.index == $past(req_reg.data_byte[INDEX_W-1:0])))
        else $error("object index write not taken");
`endif

endmodule
